FILE: sv/bfsa_pkg.sv
// Package for the best-fit segment allocator.
// Holds the request and response types and the fixed codes used by the allocator core.
// Depends on nothing.
package bfsa_pkg;

    localparam int OWNER_W = 9;
    localparam logic [OWNER_W-1:0] HOLE_MARK = 9'h100;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] pid;
        logic [8:0] request_size;
    } req_t;

    typedef struct packed {
        logic       ok;
        logic [8:0] free_total;
        logic [8:0] hole_count;
    } rsp_t;

endpackage

FILE: sv/bfsa_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Used for the segment table; depends on nothing.
module bfsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/best_fit_segment_allocator_core.sv
// Best-fit segment allocator: the segment table lives in one RAM with a registered read.
// Each request makes at most one scan pass and one shift pass over the single read port.
// Requests are taken one at a time; busy stays high until the result strobe is issued.
// Reset: asynchronous, active low; afterwards S_INIT writes entry 0 as a full hole.
// Each result appears on rsp with done high for one cycle; the receiver cannot stall.
module best_fit_segment_allocator_core #(
    parameter int MEM_UNITS    = 256,
    parameter int MAX_SEGMENTS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  bfsa_pkg::req_t   req,
    output logic             done,
    output bfsa_pkg::rsp_t   rsp
);

    localparam int SIZE_W = $clog2(MEM_UNITS + 1);
    localparam int CMP_W  = (SIZE_W > 9) ? SIZE_W : 9;
    localparam int IDX_W  = $clog2(MAX_SEGMENTS);
    localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int ENT_W  = bfsa_pkg::OWNER_W + SIZE_W;

    localparam logic [SIZE_W-1:0] FULL_SIZE = SIZE_W'(MEM_UNITS);

    localparam logic [3:0] S_INIT     = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_SCAN     = 4'd2;
    localparam logic [3:0] S_NEXT     = 4'd3;
    localparam logic [3:0] S_SHIFT    = 4'd4;
    localparam logic [3:0] S_ALLOC_HI = 4'd5;
    localparam logic [3:0] S_ALLOC_LO = 4'd6;
    localparam logic [3:0] S_FIN      = 4'd7;

    logic [3:0]           state_reg, state_next;
    bfsa_pkg::req_t       req_reg, req_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     hole_cnt_reg, hole_cnt_next;
    logic [SIZE_W-1:0]    free_reg, free_next;
    logic [CNT_W-1:0]     scan_idx_reg, scan_idx_next;
    logic                 rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic [SIZE_W-1:0]    best_size_reg, best_size_next;
    logic                 last_hole_reg, last_hole_next;
    logic [SIZE_W-1:0]    last_size_reg, last_size_next;
    logic                 prv_hole_reg, prv_hole_next;
    logic [SIZE_W-1:0]    prv_size_reg, prv_size_next;
    logic [SIZE_W-1:0]    cur_size_reg, cur_size_next;
    logic [IDX_W-1:0]     sh_src_reg, sh_src_next;
    logic [CNT_W-1:0]     sh_left_reg, sh_left_next;
    logic                 sh_up_reg, sh_up_next;
    logic                 sh_two_reg, sh_two_next;
    logic [3:0]           sh_ret_reg, sh_ret_next;
    logic                 ok_reg, ok_next;
    logic                 done_reg, done_next;
    bfsa_pkg::rsp_t       rsp_reg, rsp_next;

    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [ENT_W-1:0]     mem_wdata;
    logic [IDX_W-1:0]     mem_raddr;
    logic [ENT_W-1:0]     mem_rdata;

    logic [bfsa_pkg::OWNER_W-1:0] rd_owner;
    logic [SIZE_W-1:0]            rd_size;
    logic                         rd_hole;
    logic                         issue;
    logic [CMP_W-1:0]             req_size_c;
    logic [SIZE_W-1:0]            req_size_s;
    logic [bfsa_pkg::OWNER_W-1:0] pid_owner;
    logic                         nxt_hole;

    bfsa_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_SEGMENTS)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign rd_owner   = mem_rdata[ENT_W-1:SIZE_W];
    assign rd_size    = mem_rdata[SIZE_W-1:0];
    assign rd_hole    = (rd_owner == bfsa_pkg::HOLE_MARK);
    assign req_size_c = CMP_W'(req_reg.request_size);
    assign req_size_s = SIZE_W'(req_reg.request_size);
    assign pid_owner  = {1'b0, req_reg.pid};
    assign nxt_hole   = rd_vld_reg && rd_hole;

    // The scan walks entries below segment_count; the shift pass walks its own range.
    assign issue = ((state_reg == S_SCAN) && (scan_idx_reg < count_reg)) ||
                   ((state_reg == S_SHIFT) && (sh_left_reg != '0));
    assign mem_raddr = (state_reg == S_SCAN) ? scan_idx_reg[IDX_W-1:0] : sh_src_reg;

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        count_next     = count_reg;
        hole_cnt_next  = hole_cnt_reg;
        free_next      = free_reg;
        scan_idx_next  = scan_idx_reg;
        rd_vld_next    = issue;
        rd_idx_next    = mem_raddr;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_size_next = best_size_reg;
        last_hole_next = last_hole_reg;
        last_size_next = last_size_reg;
        prv_hole_next  = prv_hole_reg;
        prv_size_next  = prv_size_reg;
        cur_size_next  = cur_size_reg;
        sh_src_next    = sh_src_reg;
        sh_left_next   = sh_left_reg;
        sh_up_next     = sh_up_reg;
        sh_two_next    = sh_two_reg;
        sh_ret_next    = sh_ret_reg;
        ok_next        = ok_reg;
        done_next      = 1'b0;
        rsp_next       = rsp_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;

        unique case (state_reg)
            S_INIT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                mem_wdata  = {bfsa_pkg::HOLE_MARK, FULL_SIZE};
                state_next = S_IDLE;
            end

            S_IDLE:
            begin
                if (start)
                begin
                    req_next       = req;
                    scan_idx_next  = '0;
                    found_next     = 1'b0;
                    last_hole_next = 1'b0;
                    if ((req.op == bfsa_pkg::OP_ALLOC) &&
                        ((req.request_size == '0) ||
                         (CMP_W'(req.request_size) > CMP_W'(free_reg))))
                    begin
                        ok_next    = 1'b0;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (issue)
                begin
                    scan_idx_next = CNT_W'(scan_idx_reg + CNT_W'(1));
                end
                if (rd_vld_reg)
                begin
                    last_hole_next = rd_hole;
                    last_size_next = rd_size;
                    if (req_reg.op == bfsa_pkg::OP_ALLOC)
                    begin
                        // Ties go to the later hole.
                        if (rd_hole && (CMP_W'(rd_size) >= req_size_c) &&
                            (!found_reg || (rd_size <= best_size_reg)))
                        begin
                            found_next     = 1'b1;
                            best_idx_next  = rd_idx_reg;
                            best_size_next = rd_size;
                        end
                    end
                    else if (rd_owner == pid_owner)
                    begin
                        // The read of the following entry is already in flight.
                        prv_hole_next = last_hole_reg;
                        prv_size_next = last_size_reg;
                        cur_size_next = rd_size;
                        best_idx_next = rd_idx_reg;
                        state_next    = S_NEXT;
                    end
                end
                else if (!issue)
                begin
                    ok_next    = 1'b0;
                    state_next = S_FIN;
                    if ((req_reg.op == bfsa_pkg::OP_ALLOC) && found_reg)
                    begin
                        if (best_size_reg == req_size_s)
                        begin
                            mem_we        = 1'b1;
                            mem_waddr     = best_idx_reg;
                            mem_wdata     = {pid_owner, best_size_reg};
                            hole_cnt_next = CNT_W'(hole_cnt_reg - CNT_W'(1));
                            free_next     = SIZE_W'(free_reg - req_size_s);
                            ok_next       = 1'b1;
                        end
                        else if (count_reg != CNT_W'(MAX_SEGMENTS))
                        begin
                            sh_src_next  = IDX_W'(count_reg - CNT_W'(1));
                            sh_left_next = CNT_W'(count_reg - CNT_W'(best_idx_reg) -
                                                  CNT_W'(1));
                            sh_up_next   = 1'b1;
                            sh_two_next  = 1'b0;
                            sh_ret_next  = S_ALLOC_HI;
                            state_next   = S_SHIFT;
                        end
                    end
                end
            end

            S_NEXT:
            begin
                free_next  = SIZE_W'(free_reg + cur_size_reg);
                ok_next    = 1'b1;
                sh_up_next = 1'b0;
                sh_ret_next = S_FIN;
                mem_we     = 1'b1;
                priority if (prv_hole_reg && nxt_hole)
                begin
                    mem_waddr     = IDX_W'(best_idx_reg - IDX_W'(1));
                    mem_wdata     = {bfsa_pkg::HOLE_MARK,
                                     SIZE_W'(prv_size_reg + cur_size_reg + rd_size)};
                    count_next    = CNT_W'(count_reg - CNT_W'(2));
                    hole_cnt_next = CNT_W'(hole_cnt_reg - CNT_W'(1));
                    sh_src_next   = IDX_W'(best_idx_reg + IDX_W'(2));
                    sh_left_next  = CNT_W'(count_reg - CNT_W'(best_idx_reg) - CNT_W'(2));
                    sh_two_next   = 1'b1;
                    state_next    = S_SHIFT;
                end
                else if (nxt_hole)
                begin
                    mem_waddr    = best_idx_reg;
                    mem_wdata    = {bfsa_pkg::HOLE_MARK, SIZE_W'(cur_size_reg + rd_size)};
                    count_next   = CNT_W'(count_reg - CNT_W'(1));
                    sh_src_next  = IDX_W'(best_idx_reg + IDX_W'(2));
                    sh_left_next = CNT_W'(count_reg - CNT_W'(best_idx_reg) - CNT_W'(2));
                    sh_two_next  = 1'b0;
                    state_next   = S_SHIFT;
                end
                else if (prv_hole_reg)
                begin
                    mem_waddr    = IDX_W'(best_idx_reg - IDX_W'(1));
                    mem_wdata    = {bfsa_pkg::HOLE_MARK,
                                    SIZE_W'(prv_size_reg + cur_size_reg)};
                    count_next   = CNT_W'(count_reg - CNT_W'(1));
                    sh_src_next  = IDX_W'(best_idx_reg + IDX_W'(1));
                    sh_left_next = CNT_W'(count_reg - CNT_W'(best_idx_reg) - CNT_W'(1));
                    sh_two_next  = 1'b0;
                    state_next   = S_SHIFT;
                end
                else
                begin
                    mem_waddr     = best_idx_reg;
                    mem_wdata     = {bfsa_pkg::HOLE_MARK, cur_size_reg};
                    hole_cnt_next = CNT_W'(hole_cnt_reg + CNT_W'(1));
                    state_next    = S_FIN;
                end
            end

            S_SHIFT:
            begin
                // Read one entry per cycle and write it back one or two places away.
                if (issue)
                begin
                    sh_src_next  = sh_up_reg ? IDX_W'(sh_src_reg - IDX_W'(1))
                                             : IDX_W'(sh_src_reg + IDX_W'(1));
                    sh_left_next = CNT_W'(sh_left_reg - CNT_W'(1));
                end
                if (rd_vld_reg)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata;
                    if (sh_up_reg)
                    begin
                        mem_waddr = IDX_W'(rd_idx_reg + IDX_W'(1));
                    end
                    else if (sh_two_reg)
                    begin
                        mem_waddr = IDX_W'(rd_idx_reg - IDX_W'(2));
                    end
                    else
                    begin
                        mem_waddr = IDX_W'(rd_idx_reg - IDX_W'(1));
                    end
                end
                else if (!issue)
                begin
                    state_next = sh_ret_reg;
                end
            end

            S_ALLOC_HI:
            begin
                mem_we     = 1'b1;
                mem_waddr  = IDX_W'(best_idx_reg + IDX_W'(1));
                mem_wdata  = {bfsa_pkg::HOLE_MARK, SIZE_W'(best_size_reg - req_size_s)};
                state_next = S_ALLOC_LO;
            end

            S_ALLOC_LO:
            begin
                mem_we     = 1'b1;
                mem_waddr  = best_idx_reg;
                mem_wdata  = {pid_owner, req_size_s};
                count_next = CNT_W'(count_reg + CNT_W'(1));
                free_next  = SIZE_W'(free_reg - req_size_s);
                ok_next    = 1'b1;
                state_next = S_FIN;
            end

            S_FIN:
            begin
                done_next           = 1'b1;
                rsp_next.ok         = ok_reg;
                rsp_next.free_total = 9'(free_reg);
                rsp_next.hole_count = 9'(hole_cnt_reg);
                state_next          = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            req_reg       <= '0;
            count_reg     <= CNT_W'(1);
            hole_cnt_reg  <= CNT_W'(1);
            free_reg      <= FULL_SIZE;
            scan_idx_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            rd_idx_reg    <= '0;
            found_reg     <= 1'b0;
            best_idx_reg  <= '0;
            best_size_reg <= '0;
            last_hole_reg <= 1'b0;
            last_size_reg <= '0;
            prv_hole_reg  <= 1'b0;
            prv_size_reg  <= '0;
            cur_size_reg  <= '0;
            sh_src_reg    <= '0;
            sh_left_reg   <= '0;
            sh_up_reg     <= 1'b0;
            sh_two_reg    <= 1'b0;
            sh_ret_reg    <= S_FIN;
            ok_reg        <= 1'b0;
            done_reg      <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            req_reg       <= req_next;
            count_reg     <= count_next;
            hole_cnt_reg  <= hole_cnt_next;
            free_reg      <= free_next;
            scan_idx_reg  <= scan_idx_next;
            rd_vld_reg    <= rd_vld_next;
            rd_idx_reg    <= rd_idx_next;
            found_reg     <= found_next;
            best_idx_reg  <= best_idx_next;
            best_size_reg <= best_size_next;
            last_hole_reg <= last_hole_next;
            last_size_reg <= last_size_next;
            prv_hole_reg  <= prv_hole_next;
            prv_size_reg  <= prv_size_next;
            cur_size_reg  <= cur_size_next;
            sh_src_reg    <= sh_src_next;
            sh_left_reg   <= sh_left_next;
            sh_up_reg     <= sh_up_next;
            sh_two_reg    <= sh_two_next;
            sh_ret_reg    <= sh_ret_next;
            ok_reg        <= ok_next;
            done_reg      <= done_next;
            rsp_reg       <= rsp_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) && (count_reg <= CNT_W'(MAX_SEGMENTS)))
        else $error("segment count out of range");

    a_holes_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hole_cnt_reg <= count_reg)
        else $error("more holes than segments");

    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= FULL_SIZE)
        else $error("free units exceed the store");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted without going busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

endmodule
